// ===== design/apdec_pkg.sv =====
// Shared types and constants of the allpass decimate-by-two block.
// Used by apdec_ctrl, apdec_dp and the top level; depends on nothing.
package apdec_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int COEF_W   = 16;
    localparam int SEL_W    = 3;
    localparam int STEP_W   = 3;

    // section select: {branch, stage}; branch 0 = lower (even), 1 = upper (odd)
    localparam logic [SEL_W-1:0] SEL_L0 = 3'b000;
    localparam logic [SEL_W-1:0] SEL_L1 = 3'b001;
    localparam logic [SEL_W-1:0] SEL_L2 = 3'b010;
    localparam logic [SEL_W-1:0] SEL_U0 = 3'b100;
    localparam logic [SEL_W-1:0] SEL_U1 = 3'b101;
    localparam logic [SEL_W-1:0] SEL_U2 = 3'b110;

    localparam logic [1:0] STAGE_LAST = 2'd2;

    localparam logic [ACC_W-1:0]    ROUND_ADD = 32'd1024;
    localparam int                  OUT_SHIFT = 11;
    localparam logic [SAMPLE_W-1:0] SAT_MAX   = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_MIN   = 16'h8000;

    // last sequencer step; mul runs on steps 0..LAST-1, add on 1..LAST
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic [SEL_W-1:0] mul_sel;
        logic             add_en;
        logic [SEL_W-1:0] add_sel;
        logic             out_load;
    } apdec_cmd_t;

    function automatic logic [COEF_W-1:0] coef_of(input logic [SEL_W-1:0] sel);
        logic [COEF_W-1:0] c;
        case (sel)
            SEL_L0:  c = 16'd12199;
            SEL_L1:  c = 16'd37471;
            SEL_L2:  c = 16'd60255;
            SEL_U0:  c = 16'd3284;
            SEL_U1:  c = 16'd24441;
            SEL_U2:  c = 16'd49528;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/apdec_ctrl.sv =====
// Sequencer for the allpass decimator: accepts a pair, steps the shared
// multiplier schedule, loads the output register. Depends on apdec_pkg.
module apdec_ctrl
    import apdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output apdec_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [STEP_W-1:0] add_step;
    logic              accept;
    logic              out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign add_step  = step_reg - 3'd1;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.mul_sel  = {step_reg[0], step_reg[2:1]};
        cmd.add_sel  = {add_step[0], add_step[2:1]};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                cmd.mul_en = (step_reg != STEP_LAST);
                cmd.add_en = (step_reg != '0);
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a request starts the schedule at step zero
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_RUN) && (step_reg == '0))
        else $error("schedule did not start after request");

    // the last step hands over to output
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && (step_reg == STEP_LAST) |=> (state_reg == S_FIN))
        else $error("schedule did not finish");

    // output register is never overwritten while its result is unread
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    // no new pair is taken while a pair is being worked on
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RUN) || (state_reg == S_FIN)) |-> !in_ready)
        else $error("ready while busy");

endmodule

// ===== design/apdec_dp.sv =====
// Datapath of the allpass decimator: eight filter memories, one shared
// 32x16 multiplier, output rounding and saturation. Depends on apdec_pkg.
module apdec_dp
    import apdec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  apdec_cmd_t          cmd,
    input  logic [SAMPLE_W-1:0] in_even,
    input  logic [SAMPLE_W-1:0] in_odd,
    input  logic                in_last,
    output logic [SAMPLE_W-1:0] out_sample,
    output logic                out_last
);

    logic [ACC_W-1:0] m_reg [8];
    logic [ACC_W-1:0] m_next [8];
    logic [ACC_W-1:0] cur_lo_reg, cur_lo_next;
    logic [ACC_W-1:0] cur_hi_reg, cur_hi_next;
    logic [ACC_W-1:0] prod_reg, prod_next;
    logic             last_reg, last_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                out_last_reg, out_last_next;

    logic [ACC_W-1:0]        mul_sub;
    logic [ACC_W-1:0]        mul_cur;
    logic signed [ACC_W-1:0] diff;
    logic signed [48:0]      prod_full;
    logic [ACC_W-1:0]        add_prev;
    logic [ACC_W-1:0]        add_sum;
    logic [ACC_W-1:0]        add_cur;
    logic [2:0]              add_idx;
    logic [ACC_W-1:0]        out_sum;
    logic [20:0]             out_shift;

    // operands of the multiply: section input minus the next stage memory
    always_comb
    begin
        case (cmd.mul_sel)
            SEL_L0:  mul_sub = m_reg[1];
            SEL_L1:  mul_sub = m_reg[2];
            SEL_L2:  mul_sub = m_reg[3];
            SEL_U0:  mul_sub = m_reg[5];
            SEL_U1:  mul_sub = m_reg[6];
            SEL_U2:  mul_sub = m_reg[7];
            default: mul_sub = '0;
        endcase
        case (cmd.add_sel)
            SEL_L0:  add_prev = m_reg[0];
            SEL_L1:  add_prev = m_reg[1];
            SEL_L2:  add_prev = m_reg[2];
            SEL_U0:  add_prev = m_reg[4];
            SEL_U1:  add_prev = m_reg[5];
            SEL_U2:  add_prev = m_reg[6];
            default: add_prev = '0;
        endcase
    end

    assign mul_cur   = cmd.mul_sel[2] ? cur_hi_reg : cur_lo_reg;
    assign diff      = $signed(mul_cur - mul_sub);
    assign prod_full = diff * $signed({1'b0, coef_of(cmd.mul_sel)});
    // floor(p / 65536), kept to 32 bits
    assign prod_next = cmd.mul_en ? prod_full[47:16] : prod_reg;

    assign add_sum = add_prev + prod_reg;
    assign add_cur = cmd.add_sel[2] ? cur_hi_reg : cur_lo_reg;
    assign add_idx = cmd.add_sel;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            m_next[i] = m_reg[i];
        end
        cur_lo_next = cur_lo_reg;
        cur_hi_next = cur_hi_reg;
        last_next   = last_reg;
        if (cmd.load)
        begin
            cur_lo_next = {{6{in_even[SAMPLE_W-1]}}, in_even, 10'b0};
            cur_hi_next = {{6{in_odd[SAMPLE_W-1]}}, in_odd, 10'b0};
            last_next   = in_last;
        end
        if (cmd.add_en)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (3'(i) == add_idx)
                begin
                    m_next[i] = add_cur;
                end
                // last stage writes the branch output memory
                if ((add_idx[1:0] == STAGE_LAST) && (3'(i) == {add_idx[2], 2'd3}))
                begin
                    m_next[i] = add_sum;
                end
            end
            if (add_idx[1:0] != STAGE_LAST)
            begin
                if (add_idx[2])
                begin
                    cur_hi_next = add_sum;
                end
                else
                begin
                    cur_lo_next = add_sum;
                end
            end
        end
    end

    // branch sum, round, shift, saturate
    assign out_sum   = m_reg[3] + m_reg[7] + ROUND_ADD;
    assign out_shift = out_sum[ACC_W-1:OUT_SHIFT];

    always_comb
    begin
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        if (cmd.out_load)
        begin
            out_last_next = last_reg;
            if ((out_shift[20:15] == 6'b000000) || (out_shift[20:15] == 6'b111111))
            begin
                out_sample_next = out_shift[15:0];
            end
            else if (out_shift[20])
            begin
                out_sample_next = SAT_MIN;
            end
            else
            begin
                out_sample_next = SAT_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                m_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                m_reg[i] <= m_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_lo_reg     <= cur_lo_next;
        cur_hi_reg     <= cur_hi_next;
        prod_reg       <= prod_next;
        last_reg       <= last_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== design/allpass_decimate_by_two.sv =====
// Top level of the allpass half-band decimator by two.
// Instantiates apdec_ctrl and apdec_dp; depends on apdec_pkg.
//
// Usage:
//   s_axis carries one sample pair per request: tdata[15:0] is the even
//   sample (lower branch), tdata[31:16] the odd sample (upper branch),
//   tlast marks the last pair of a buffer and is copied to m_axis_tlast.
//   m_axis carries one decimated, saturated sample per pair in tdata[15:0].
// Timing:
//   A pair is accepted in the idle state, runs the multiply/add schedule
//   and is loaded into the output register, then the next pair is ready.
//   The six allpass sections share one 32x16 multiplier; lower and upper
//   branch sections are interleaved so each product is added one cycle
//   after it is formed.
// Reset:
//   rst_n clears all eight filter memories to zero, the sequencer to idle
//   and the output valid flag.
// Stall:
//   A finished result waits in the output register; the next pair is still
//   accepted and worked on, and only its final load waits for the output
//   register to drain.
module allpass_decimate_by_two
    import apdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] sample_even, [31:16] sample_odd
    input  logic        s_axis_tlast,   // block_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    output logic        m_axis_tlast    // block_end_out
);

    apdec_cmd_t cmd;

    apdec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    apdec_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_even    (s_axis_tdata[15:0]),
        .in_odd     (s_axis_tdata[31:16]),
        .in_last    (s_axis_tlast),
        .out_sample (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
